/* hw/rtl/kwm_pkg.sv */
// shared types and constants of the k-way merge heap core
package kwm_pkg;

  localparam int NumSources = 16;
  localparam int AddrW      = (NumSources > 1) ? $clog2(NumSources) : 1;
  localparam int CntW       = $clog2(NumSources + 1);
  localparam int KeyW       = 32;
  localparam int SrcW       = 4;
  localparam int FuncW      = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_BUILD  = 2'd1,
    FUNC_REFILL = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_MERGING = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic signed [KeyW-1:0] key;
    logic                   present;
  } in_item_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key_out;
    logic [SrcW-1:0]        source_out;
    logic                   valid_res;
  } out_item_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [SrcW-1:0]        src;
    logic                   present;
  } slot_t;

endpackage

/* hw/rtl/k_way_merge_heap_core.sv */
// k-way merge over a binary min-heap of stream heads kept in one slot memory
// load: one cycle per transfer, loads may follow back to back
// refill: the root takes the new head, or the last entry if the source ran dry, and
//   sinks level by level (at most log2 of the heap size levels), then the root is emitted
// build: empty slots take the tail entry, inner nodes sink from the last up, root is emitted
// reset clears control and phase; the slot memory is not cleared and is only read once written
module k_way_merge_heap_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kwm_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kwm_pkg::out_item_t out_data_o
);
  import kwm_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_B_RD  = 14'b00000000000010,
    ST_B_CHK = 14'b00000000000100,
    ST_B_MOV = 14'b00000000001000,
    ST_H_NXT = 14'b00000000010000,
    ST_S_LD  = 14'b00000000100000,
    ST_S_TK  = 14'b00000001000000,
    ST_S_CHK = 14'b00000010000000,
    ST_S_R   = 14'b00000100000000,
    ST_S_C   = 14'b00001000000000,
    ST_S_WR  = 14'b00010000000000,
    ST_E_RD  = 14'b00100000000000,
    ST_E_WT  = 14'b01000000000000,
    ST_E_OUT = 14'b10000000000000
  } state_e;

  state_e    state_q, state_d;
  phase_e    phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  loaded_q, loaded_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  sub_q, sub_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic             has_r_q, has_r_d;
  logic             building_q, building_d;
  slot_t            tk_q, tk_d;
  slot_t            lft_q, lft_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // slot memory, one write and one registered read per cycle
  slot_t            slot_mem [NumSources];
  slot_t            rd_q;
  logic [AddrW-1:0] raddr;
  logic             we;
  logic [AddrW-1:0] waddr;
  slot_t            wdata;

  logic [AddrW:0]   lft_ix;
  logic [AddrW+1:0] rgt_ix;
  logic [CntW-1:0]  base;
  logic             pick_r;
  slot_t            pick;
  logic [AddrW-1:0] pick_ix;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lft_ix  = {pos_q, 1'b1};
  assign rgt_ix  = (AddrW+2)'(lft_ix) + (AddrW+2)'(1);
  assign base    = (phase_q != PH_LOADING) ? '0 : loaded_q;
  assign pick_r  = has_r_q && ($signed(rd_q.key) < $signed(lft_q.key));
  assign pick    = pick_r ? rd_q : lft_q;
  assign pick_ix = pick_r ? rgt_ix[AddrW-1:0] : lft_ix[AddrW-1:0];

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    loaded_d    = loaded_q;
    idx_d       = idx_q;
    sub_d       = sub_q;
    pos_d       = pos_q;
    has_r_d     = has_r_q;
    building_d  = building_q;
    tk_d        = tk_q;
    lft_d       = lft_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    raddr       = '0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = tk_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.func)
            FUNC_LOAD: begin
              if (phase_q != PH_LOADING) begin
                phase_d = PH_LOADING;
                cnt_d   = '0;
              end
              loaded_d = base;
              if (base < CntW'(NumSources)) begin
                we       = 1'b1;
                waddr    = AddrW'(base);
                wdata    = '{key: in_data_i.key, src: SrcW'(base),
                             present: in_data_i.present};
                loaded_d = base + CntW'(1);
              end
            end
            FUNC_BUILD: begin
              if (phase_q == PH_LOADING) begin
                cnt_d   = loaded_q;
                idx_d   = '0;
                state_d = ST_B_RD;
              end
            end
            FUNC_REFILL: begin
              if (phase_q == PH_MERGING && cnt_q != '0) begin
                pos_d = '0;
                if (in_data_i.present) begin
                  tk_d    = '{key: in_data_i.key, src: res_q.source_out, present: 1'b1};
                  state_d = ST_S_CHK;
                end else begin
                  // last entry moves into the root
                  cnt_d   = cnt_q - CntW'(1);
                  state_d = (cnt_q == CntW'(1)) ? ST_E_RD : ST_S_LD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_B_RD: begin
        if (idx_q < cnt_q) begin
          raddr   = AddrW'(idx_q);
          state_d = ST_B_CHK;
        end else begin
          sub_d      = cnt_q >> 1;
          building_d = 1'b1;
          state_d    = ST_H_NXT;
        end
      end
      ST_B_CHK: begin
        if (rd_q.present) begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_B_RD;
        end else begin
          raddr   = AddrW'(cnt_q - CntW'(1));
          cnt_d   = cnt_q - CntW'(1);
          state_d = ST_B_MOV;
        end
      end
      ST_B_MOV: begin
        we      = 1'b1;
        waddr   = AddrW'(idx_q);
        wdata   = rd_q;
        state_d = ST_B_RD;
      end
      ST_H_NXT: begin
        if (sub_q == '0) begin
          building_d = 1'b0;
          state_d    = ST_E_RD;
        end else begin
          sub_d   = sub_q - CntW'(1);
          pos_d   = AddrW'(sub_q - CntW'(1));
          state_d = ST_S_LD;
        end
      end
      ST_S_LD: begin
        raddr   = building_q ? pos_q : AddrW'(cnt_q);
        state_d = ST_S_TK;
      end
      ST_S_TK: begin
        tk_d    = rd_q;
        state_d = ST_S_CHK;
      end
      ST_S_CHK: begin
        if ((AddrW+1)'(cnt_q) > lft_ix) begin
          raddr   = lft_ix[AddrW-1:0];
          state_d = ST_S_R;
        end else begin
          state_d = ST_S_WR;
        end
      end
      ST_S_R: begin
        lft_d = rd_q;
        if ((AddrW+2)'(cnt_q) > rgt_ix) begin
          raddr   = rgt_ix[AddrW-1:0];
          has_r_d = 1'b1;
        end else begin
          has_r_d = 1'b0;
        end
        state_d = ST_S_C;
      end
      ST_S_C: begin
        if ($signed(pick.key) < $signed(tk_q.key)) begin
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = pick;
          pos_d   = pick_ix;
          state_d = ST_S_CHK;
        end else begin
          state_d = ST_S_WR;
        end
      end
      ST_S_WR: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = tk_q;
        state_d = building_q ? ST_H_NXT : ST_E_RD;
      end
      ST_E_RD: begin
        if (cnt_q == '0) begin
          res_d   = '0;
          phase_d = PH_DONE;
          state_d = ST_E_OUT;
        end else begin
          raddr   = '0;
          state_d = ST_E_WT;
        end
      end
      ST_E_WT: begin
        res_d   = '{key_out: rd_q.key, source_out: rd_q.src, valid_res: 1'b1};
        phase_d = PH_MERGING;
        state_d = ST_E_OUT;
      end
      ST_E_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // no read whose data is used targets an entry written in the same cycle, so no bypass
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    rd_q <= slot_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LOADING;
      cnt_q       <= '0;
      loaded_q    <= '0;
      idx_q       <= '0;
      sub_q       <= '0;
      pos_q       <= '0;
      has_r_q     <= 1'b0;
      building_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      loaded_q    <= loaded_d;
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      pos_q       <= pos_d;
      has_r_q     <= has_r_d;
      building_q  <= building_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tk_q  <= tk_d;
    lft_q <= lft_d;
    res_q <= res_d;
    out_q <= out_d;
  end

endmodule

/* hw/rtl/kwm_chk.sv */
// port-level assertions for the k-way merge heap core, bound to the top level
module kwm_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input kwm_pkg::in_item_t  in_data_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input kwm_pkg::out_item_t out_data_i
);
  import kwm_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // the end marker carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.valid_res |->
      out_data_i.key_out == '0 && out_data_i.source_out == '0)
    else $error("end marker with nonzero fields");

  // a load transfer finishes at once and leaves the input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i && in_data_i.func == FUNC_LOAD |=> !in_stall_i)
    else $error("input stalled after a load");

  // a new result only appears while the core is busy with an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result without a busy core");

endmodule

bind k_way_merge_heap_core kwm_chk u_kwm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

/* bench/kwm_merge_checker.sv */
`timescale 1ns / 1ps
// merge heap checker: watches both channels, predicts each transfer and compares results
module kwm_merge_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  kwm_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  kwm_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 merged_count_o,
  output int                 finish_count_o
);
  import kwm_pkg::*;

  slot_t           heap_slot [NumSources];
  logic [CntW-1:0] heap_size;
  logic [CntW-1:0] loaded_size;
  phase_e          merge_phase;
  out_item_t       expected_merge_q [$];
  int              fail_count;
  int              merged_count;
  int              finish_count;

  // sink the entry at pos until no child is strictly smaller
  task automatic sink_slot(input int pos);
    slot_t held;
    int    right;
    int    pick;
    held  = heap_slot[pos];
    right = (pos + 1) * 2;
    while (right <= int'(heap_size)) begin
      if (right < int'(heap_size) && heap_slot[right].key < heap_slot[right - 1].key) begin
        pick = right;
      end else begin
        pick = right - 1;
      end
      if (heap_slot[pick].key < held.key) begin
        heap_slot[pos] = heap_slot[pick];
        pos            = pick;
        right          = (pos + 1) * 2;
      end else begin
        break;
      end
    end
    heap_slot[pos] = held;
  endtask

  task automatic predict_transfer(input in_item_t item);
    out_item_t res;
    int        n;
    int        i;
    int        s;
    bit        emits;
    emits = 1'b0;
    case (item.func)
      FUNC_LOAD: begin
        // a load after a merge drops the old set
        if (merge_phase != PH_LOADING) begin
          merge_phase = PH_LOADING;
          loaded_size = '0;
          heap_size   = '0;
        end
        if (int'(loaded_size) < NumSources) begin
          heap_slot[loaded_size].key     = item.key;
          heap_slot[loaded_size].src     = loaded_size[SrcW-1:0];
          heap_slot[loaded_size].present = item.present;
          loaded_size = loaded_size + 1'b1;
        end
      end
      FUNC_BUILD: begin
        if (merge_phase == PH_LOADING) begin
          n = int'(loaded_size);
          i = 0;
          // fill each empty slot from the tail
          while (i < n) begin
            if (!heap_slot[i].present) begin
              heap_slot[i] = heap_slot[n - 1];
              n--;
            end else begin
              i++;
            end
          end
          heap_size = n[CntW-1:0];
          for (s = n / 2 - 1; s >= 0; s--) begin
            sink_slot(s);
          end
          emits = 1'b1;
        end
      end
      FUNC_REFILL: begin
        if (merge_phase == PH_MERGING && heap_size != 0) begin
          if (item.present) begin
            heap_slot[0].key = item.key;
          end else begin
            heap_slot[0] = heap_slot[heap_size - 1'b1];
            heap_size    = heap_size - 1'b1;
          end
          if (heap_size != 0) begin
            sink_slot(0);
          end
          emits = 1'b1;
        end
      end
      default: ;
    endcase
    if (emits) begin
      if (heap_size == 0) begin
        merge_phase = PH_DONE;
        res         = '0;
      end else begin
        merge_phase    = PH_MERGING;
        res.key_out    = heap_slot[0].key;
        res.source_out = heap_slot[0].src;
        res.valid_res  = 1'b1;
      end
      expected_merge_q.push_back(res);
    end
  endtask

  task automatic report_field(input string field, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (got.valid_res) begin
      merged_count++;
    end else begin
      finish_count++;
    end
    if (expected_merge_q.size() == 0) begin
      fail_count++;
      $display("%0t: expected no result, got key %0d source %0d valid %0b",
               $time, got.key_out, got.source_out, got.valid_res);
    end else begin
      want = expected_merge_q.pop_front();
      if (got.key_out !== want.key_out) begin
        report_field("key_out", want.key_out, got.key_out);
      end
      if (got.source_out !== want.source_out) begin
        report_field("source_out", want.source_out, got.source_out);
      end
      if (got.valid_res !== want.valid_res) begin
        report_field("valid_res", want.valid_res, got.valid_res);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_phase  = PH_LOADING;
      heap_size    = '0;
      loaded_size  = '0;
      fail_count   = 0;
      merged_count = 0;
      finish_count = 0;
      expected_merge_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_transfer(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_data_i);
      end
    end
    fail_count_o   <= fail_count;
    pending_o      <= expected_merge_q.size();
    merged_count_o <= merged_count;
    finish_count_o <= finish_count;
  end

endmodule

/* bench/k_way_merge_heap_core_test.sv */
`timescale 1ns / 1ps
// testbench top for the k-way merge heap core: reset, stimulus, idling and verdict
module k_way_merge_heap_core_test;
  import kwm_pkg::*;

  localparam logic [FuncW-1:0]       FuncUnused  = 2'd3;
  localparam int                     TargetItems = 700;
  localparam int                     CycleLimit  = 600000;
  localparam int                     DrainCycles = 200;
  localparam logic signed [KeyW-1:0] KeyMin      = 32'sh8000_0000;
  localparam logic signed [KeyW-1:0] KeyMax      = 32'sh7fff_ffff;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int merged_count;
  int finish_count;
  int cycle_count = 0;
  int counted     = 0;
  int items_sent  = 0;
  int sets_run    = 0;
  int stall_run   = 0;
  int stall_roll;
  bit steady      = 1'b0;  // no sender gaps while set

  k_way_merge_heap_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  kwm_merge_checker merge_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .merged_count_o (merged_count),
    .finish_count_o (finish_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls: runs of random length, mostly short, some long, some stall-free
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 6);
      end else if (stall_roll < 60) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(20, 60);
      end else if (stall_roll < 93) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(8, 40);
      end
    end
  end

  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 65) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [KeyW-1:0] next_key();
    case ($urandom_range(0, 9))
      0:          return KeyMin;
      1:          return KeyMax;
      2, 3, 4, 5: return int'($urandom_range(0, 8)) - 4;  // narrow range gives ties
      default:    return $urandom;
    endcase
  endfunction

  // returns at the edge where the transfer happens
  task automatic send_item(input logic [FuncW-1:0] func, input logic signed [KeyW-1:0] key,
                           input logic present);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data  <= '{func: func, key: key, present: present};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic run_directed();
    int                     i;
    logic signed [KeyW-1:0] k;
    send_item(FuncUnused, KeyMax, 1'b1);
    send_item(FUNC_REFILL, 32'sd7, 1'b1);       // refill while still loading
    send_item(FUNC_BUILD, '0, 1'b1);            // nothing loaded: ends at once
    counted++;
    send_item(FUNC_REFILL, KeyMin, 1'b0);       // refill after the end
    // one set past capacity, extreme keys, ties, empties including the last slot
    for (i = 0; i <= NumSources; i++) begin
      case (i % 4)
        0:       k = KeyMax - i;
        1:       k = KeyMin + i;
        2:       k = -1;
        default: k = 0;
      endcase
      send_item(FUNC_LOAD, k, (i % 5 != 2) && (i != NumSources - 1));
      if (i < NumSources) begin
        counted++;
      end
    end
    send_item(FUNC_BUILD, KeyMin, 1'b0);
    send_item(FUNC_REFILL, KeyMin, 1'b1);       // out of order value
    send_item(FUNC_REFILL, KeyMax, 1'b0);
    counted += 3;
    send_item(FUNC_BUILD, 32'sd1, 1'b1);        // build while merging
    send_item(FUNC_LOAD, 32'sd3, 1'b0);         // abandons the merge
    send_item(FUNC_LOAD, KeyMax, 1'b0);
    send_item(FUNC_BUILD, '0, 1'b1);            // no present source
    counted += 3;
  endtask

  task automatic run_merge_set();
    int   heads;
    int   alive;
    int   i;
    int   cut;
    int   made;
    int   roll;
    bit   all_empty;
    logic present;
    steady    = ($urandom_range(0, 5) == 0);
    all_empty = ($urandom_range(0, 19) == 0);
    roll      = $urandom_range(0, 99);
    if (roll < 6) begin
      heads = 1;
    end else if (roll < 14) begin
      heads = $urandom_range(NumSources + 1, NumSources + 2);
    end else if (roll < 40) begin
      heads = NumSources;
    end else begin
      heads = $urandom_range(2, NumSources);
    end
    alive = 0;
    for (i = 0; i < heads; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item($urandom_range(0, 1) ? FuncUnused : FUNC_REFILL, next_key(),
                  1'($urandom_range(0, 1)));
      end
      present = !all_empty && ($urandom_range(0, 99) < 85);
      send_item(FUNC_LOAD, next_key(), present);
      if (i < NumSources) begin
        counted++;
        if (present) begin
          alive++;
        end
      end
    end
    send_item(FUNC_BUILD, next_key(), 1'($urandom_range(0, 1)));
    counted++;
    // now and then the merge is left unfinished and the next load abandons it
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * alive) : -1;
    made = 0;
    while (alive > 0 && made != cut) begin
      if ($urandom_range(0, 24) == 0) begin
        send_item($urandom_range(0, 1) ? FuncUnused : FUNC_BUILD, next_key(),
                  1'($urandom_range(0, 1)));
      end
      present = ($urandom_range(0, 99) < 72);
      send_item(FUNC_REFILL, next_key(), present);
      counted++;
      made++;
      if (!present) begin
        alive--;
      end
    end
    if (alive == 0 && $urandom_range(0, 3) == 0) begin
      send_item(FUNC_REFILL, next_key(), 1'($urandom_range(0, 1)));
    end
    sets_run++;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    while (counted < TargetItems) begin
      run_merge_set();
    end
    in_valid <= 1'b0;
    steady   = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d transfers in: directed cases and %0d random merge sets", items_sent, sets_run);
    $display("%0d merged elements and %0d end markers compared", merged_count, finish_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
